// ===== rtl/clm_pkg.sv =====
// clm_pkg: shared types, microcode encoding and control store for the list manager
`default_nettype none

package clm_pkg;

    localparam int UPC_W = 5;
    typedef logic [UPC_W-1:0] upc_t;

    // action decode: high bit selects delete, low bit selects back on insert
    localparam int ACT_DEL_BIT  = 1;
    localparam int ACT_BACK_BIT = 0;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] value;
    } clm_in_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] slot;
    } clm_out_t;

    typedef enum logic [3:0] {
        OP_NOP        = 4'd0,
        OP_CLEAR      = 4'd1,
        OP_ACCEPT     = 4'd2,
        OP_TAKE       = 4'd3,
        OP_POP        = 4'd4,
        OP_LINK_FRONT = 4'd5,
        OP_BACK_START = 4'd6,
        OP_WALK       = 4'd7,
        OP_LINK_TAIL  = 4'd8,
        OP_SET_HEAD   = 4'd9,
        OP_DEL_START  = 4'd10,
        OP_DEL_SCAN   = 4'd11,
        OP_UNLINK     = 4'd12,
        OP_FREE_PUSH  = 4'd13,
        OP_RESULT     = 4'd14
    } op_t;

    typedef enum logic [3:0] {
        C_NEVER      = 4'd0,
        C_ALWAYS     = 4'd1,
        C_NOT_LAST   = 4'd2,
        C_NO_ITEM    = 4'd3,
        C_DELETE     = 4'd4,
        C_FREE_EMPTY = 4'd5,
        C_BACK       = 4'd6,
        C_HEAD_NIL   = 4'd7,
        C_RD_SLOT    = 4'd8,
        C_CONTINUE   = 4'd9,
        C_NO_MATCH   = 4'd10
    } cond_t;

    typedef struct packed {
        op_t     op;
        cond_t   cond;
        upc_t    target;
        status_t status;
        logic    stall;     // hold this step while the output register is full
    } cw_t;

    typedef struct packed {
        logic clear_last;
        logic item;
        logic is_delete;
        logic is_back;
        logic free_empty;
        logic head_nil;
        logic rd_slot;
        logic scan_go;
        logic no_match;
        logic out_busy;
    } flags_t;

    localparam upc_t UA_INIT       = 5'd0;
    localparam upc_t UA_IDLE       = 5'd1;
    localparam upc_t UA_DISPATCH   = 5'd2;
    localparam upc_t UA_TAKE       = 5'd3;
    localparam upc_t UA_POP        = 5'd4;
    localparam upc_t UA_FRONT      = 5'd5;
    localparam upc_t UA_BACK       = 5'd6;
    localparam upc_t UA_WALK       = 5'd7;
    localparam upc_t UA_TAIL       = 5'd8;
    localparam upc_t UA_BACK_EMPTY = 5'd9;
    localparam upc_t UA_DONE       = 5'd10;
    localparam upc_t UA_DEL        = 5'd11;
    localparam upc_t UA_SCAN       = 5'd12;
    localparam upc_t UA_DECIDE     = 5'd13;
    localparam upc_t UA_UNLINK     = 5'd14;
    localparam upc_t UA_FREE_PUSH  = 5'd15;
    localparam upc_t UA_MISS       = 5'd16;
    localparam upc_t UA_FULL       = 5'd17;

    // control store
    function automatic cw_t ucode(input upc_t addr);
        cw_t w;
        begin
            case (addr)
                UA_INIT:       w = '{OP_CLEAR,      C_NOT_LAST,   UA_INIT,       ST_DONE,    1'b0};
                UA_IDLE:       w = '{OP_ACCEPT,     C_NO_ITEM,    UA_IDLE,       ST_DONE,    1'b0};
                UA_DISPATCH:   w = '{OP_NOP,        C_DELETE,     UA_DEL,        ST_DONE,    1'b0};
                UA_TAKE:       w = '{OP_TAKE,       C_FREE_EMPTY, UA_FULL,       ST_DONE,    1'b0};
                UA_POP:        w = '{OP_POP,        C_BACK,       UA_BACK,       ST_DONE,    1'b0};
                UA_FRONT:      w = '{OP_LINK_FRONT, C_ALWAYS,     UA_DONE,       ST_DONE,    1'b0};
                UA_BACK:       w = '{OP_BACK_START, C_HEAD_NIL,   UA_BACK_EMPTY, ST_DONE,    1'b0};
                UA_WALK:       w = '{OP_WALK,       C_RD_SLOT,    UA_WALK,       ST_DONE,    1'b0};
                UA_TAIL:       w = '{OP_LINK_TAIL,  C_ALWAYS,     UA_DONE,       ST_DONE,    1'b0};
                UA_BACK_EMPTY: w = '{OP_SET_HEAD,   C_ALWAYS,     UA_DONE,       ST_DONE,    1'b0};
                UA_DONE:       w = '{OP_RESULT,     C_ALWAYS,     UA_IDLE,       ST_DONE,    1'b1};
                UA_DEL:        w = '{OP_DEL_START,  C_HEAD_NIL,   UA_MISS,       ST_DONE,    1'b0};
                UA_SCAN:       w = '{OP_DEL_SCAN,   C_CONTINUE,   UA_SCAN,       ST_DONE,    1'b0};
                UA_DECIDE:     w = '{OP_NOP,        C_NO_MATCH,   UA_MISS,       ST_DONE,    1'b0};
                UA_UNLINK:     w = '{OP_UNLINK,     C_NEVER,      UA_IDLE,       ST_DONE,    1'b0};
                UA_FREE_PUSH:  w = '{OP_FREE_PUSH,  C_ALWAYS,     UA_DONE,       ST_DONE,    1'b0};
                UA_MISS:       w = '{OP_RESULT,     C_ALWAYS,     UA_IDLE,       ST_MISSING, 1'b1};
                UA_FULL:       w = '{OP_RESULT,     C_ALWAYS,     UA_IDLE,       ST_FULL,    1'b1};
                default:       w = '{OP_NOP,        C_ALWAYS,     UA_IDLE,       ST_DONE,    1'b0};
            endcase
            return w;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/clm_ram.sv =====
// clm_ram: generic single-write, single-read memory with registered read
`default_nettype none

module clm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/clm_seq.sv =====
// clm_seq: micro-program counter, control store lookup and jump logic
`default_nettype none

module clm_seq (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire clm_pkg::flags_t flags,
    output clm_pkg::cw_t         cw
);

    import clm_pkg::*;

    upc_t upc_reg;
    upc_t upc_next;
    logic take_jump;

    assign cw = ucode(upc_reg);

    always_comb begin
        unique case (cw.cond)
            C_NEVER:      take_jump = 1'b0;
            C_ALWAYS:     take_jump = 1'b1;
            C_NOT_LAST:   take_jump = !flags.clear_last;
            C_NO_ITEM:    take_jump = !flags.item;
            C_DELETE:     take_jump = flags.is_delete;
            C_FREE_EMPTY: take_jump = flags.free_empty;
            C_BACK:       take_jump = flags.is_back;
            C_HEAD_NIL:   take_jump = flags.head_nil;
            C_RD_SLOT:    take_jump = flags.rd_slot;
            C_CONTINUE:   take_jump = flags.scan_go;
            C_NO_MATCH:   take_jump = flags.no_match;
            default:      take_jump = 1'b0;
        endcase
    end

    always_comb begin
        if (cw.stall && flags.out_busy) begin
            upc_next = upc_reg;
        end else if (take_jump) begin
            upc_next = cw.target;
        end else begin
            upc_next = upc_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= UA_INIT;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/clm_datapath.sv =====
// clm_datapath: pointer registers, link and value stores, output register
`default_nettype none

module clm_datapath #(
    parameter int NODES = 16
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire clm_pkg::cw_t     cw,
    output clm_pkg::flags_t       flags,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire clm_pkg::clm_in_t s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output clm_pkg::clm_out_t     m_data
);

    import clm_pkg::*;

    localparam int IDX_W = $clog2(NODES);
    localparam int PTR_W = $clog2(NODES + 1);
    localparam logic [PTR_W-1:0] NIL       = PTR_W'(NODES);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(NODES - 1);

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [IDX_W-1:0] idx_t;

    function automatic logic is_slot(input ptr_t p);
        return p < NIL;
    endfunction

    function automatic ptr_t link_of(input ptr_t p);
        return is_slot(p) ? p : NIL;
    endfunction

    function automatic idx_t idx(input ptr_t p);
        return p[IDX_W-1:0];
    endfunction

    ptr_t cur_reg, cur_next;
    ptr_t prev_reg, prev_next;
    ptr_t s_reg, s_next;
    ptr_t nxt_reg, nxt_next;
    ptr_t list_head_reg, list_head_next;
    ptr_t free_head_reg, free_head_next;
    logic match_reg, match_next;
    logic [1:0] act_reg, act_next;
    logic [31:0] val_reg, val_next;
    logic out_valid_reg, out_valid_next;
    clm_out_t out_data_reg, out_data_next;

    logic link_we;
    idx_t link_waddr, link_raddr;
    ptr_t link_wdata, link_rdata;
    logic val_we;
    idx_t val_waddr, val_raddr;
    logic [31:0] val_wdata, val_rdata;

    logic out_busy;
    logic accept;
    logic scan_match;
    ptr_t scan_nxt;
    logic [PTR_W+3:0] slot_ext;

    clm_ram #(.WIDTH(PTR_W), .DEPTH(NODES)) u_link_ram (
        .clk   (aclk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    clm_ram #(.WIDTH(32), .DEPTH(NODES)) u_val_ram (
        .clk   (aclk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    assign out_busy   = out_valid_reg && !m_ready;
    assign s_ready    = (cw.op == OP_ACCEPT);
    assign accept     = s_valid && s_ready;
    assign scan_match = (val_rdata == val_reg);
    assign scan_nxt   = link_of(link_rdata);
    assign slot_ext   = {4'b0000, s_reg};

    always_comb begin
        flags.clear_last = (cur_reg == LAST_SLOT);
        flags.item       = s_valid;
        flags.is_delete  = act_reg[ACT_DEL_BIT];
        flags.is_back    = act_reg[ACT_BACK_BIT];
        flags.free_empty = !is_slot(free_head_reg);
        flags.head_nil   = !is_slot(list_head_reg);
        flags.rd_slot    = is_slot(link_rdata);
        flags.scan_go    = !scan_match && is_slot(scan_nxt);
        flags.no_match   = !match_reg;
        flags.out_busy   = out_busy;
    end

    always_comb begin
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        s_next         = s_reg;
        nxt_next       = nxt_reg;
        list_head_next = list_head_reg;
        free_head_next = free_head_reg;
        match_next     = match_reg;
        act_next       = act_reg;
        val_next       = val_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        link_we    = 1'b0;
        link_waddr = idx(cur_reg);
        link_wdata = NIL;
        link_raddr = idx(cur_reg);
        val_we     = 1'b0;
        val_waddr  = idx(free_head_reg);
        val_wdata  = val_reg;
        val_raddr  = idx(cur_reg);

        if (m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (cw.op)
            OP_NOP: begin
            end
            // reset sweep: slot i links to i+1, last slot to null
            OP_CLEAR: begin
                link_we    = 1'b1;
                link_waddr = idx(cur_reg);
                link_wdata = cur_reg + 1'b1;
                cur_next   = cur_reg + 1'b1;
            end
            OP_ACCEPT: begin
                if (accept) begin
                    act_next = s_data.action;
                    val_next = s_data.value;
                end
            end
            OP_TAKE: begin
                s_next     = free_head_reg;
                link_raddr = idx(free_head_reg);
                val_we     = is_slot(free_head_reg);
                val_waddr  = idx(free_head_reg);
                val_wdata  = val_reg;
            end
            OP_POP: begin
                free_head_next = link_of(link_rdata);
            end
            OP_LINK_FRONT: begin
                link_we        = 1'b1;
                link_waddr     = idx(s_reg);
                link_wdata     = link_of(list_head_reg);
                list_head_next = s_reg;
            end
            OP_BACK_START: begin
                link_we    = 1'b1;
                link_waddr = idx(s_reg);
                link_wdata = NIL;
                link_raddr = idx(list_head_reg);
                cur_next   = list_head_reg;
            end
            // follow links until the tail; cur holds the last node seen
            OP_WALK: begin
                link_raddr = idx(link_rdata);
                if (is_slot(link_rdata)) begin
                    cur_next = link_rdata;
                end
            end
            OP_LINK_TAIL: begin
                link_we    = is_slot(cur_reg);
                link_waddr = idx(cur_reg);
                link_wdata = s_reg;
            end
            OP_SET_HEAD: begin
                list_head_next = s_reg;
            end
            OP_DEL_START: begin
                cur_next   = list_head_reg;
                prev_next  = NIL;
                link_raddr = idx(list_head_reg);
                val_raddr  = idx(list_head_reg);
            end
            // compare the current node, step ahead on a miss
            OP_DEL_SCAN: begin
                match_next = scan_match;
                nxt_next   = scan_nxt;
                link_raddr = idx(scan_nxt);
                val_raddr  = idx(scan_nxt);
                if (!scan_match && is_slot(scan_nxt)) begin
                    prev_next = cur_reg;
                    cur_next  = scan_nxt;
                end
            end
            OP_UNLINK: begin
                s_next = cur_reg;
                if (is_slot(prev_reg)) begin
                    link_we    = 1'b1;
                    link_waddr = idx(prev_reg);
                    link_wdata = nxt_reg;
                end else begin
                    list_head_next = nxt_reg;
                end
            end
            OP_FREE_PUSH: begin
                link_we        = 1'b1;
                link_waddr     = idx(cur_reg);
                link_wdata     = link_of(free_head_reg);
                free_head_next = cur_reg;
            end
            OP_RESULT: begin
                if (!out_busy) begin
                    out_valid_next       = 1'b1;
                    out_data_next.status = cw.status;
                    out_data_next.slot   = (cw.status == ST_DONE) ? slot_ext[3:0] : 4'd0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg       <= '0;
            list_head_reg <= NIL;
            free_head_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            cur_reg       <= cur_next;
            list_head_reg <= list_head_next;
            free_head_reg <= free_head_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        prev_reg     <= prev_next;
        s_reg        <= s_next;
        nxt_reg      <= nxt_next;
        match_reg    <= match_next;
        act_reg      <= act_next;
        val_reg      <= val_next;
        out_data_reg <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== rtl/cursor_linked_list_manager_core.sv =====
// cursor_linked_list_manager_core: microcoded list manager top level
// insert at back walks the list to its tail first; delete scans from the head to the first match or the tail
// one item at a time; the next item can be taken in the cycle after its result is registered
// reset: synchronous active-low aresetn empties the list, then a link-store sweep over all NODES slots
// runs with s_ready low before the first item is taken
`default_nettype none

module cursor_linked_list_manager_core #(
    parameter int NODES = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire clm_pkg::clm_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output clm_pkg::clm_out_t      m_data
);

    import clm_pkg::*;

    cw_t    cw;
    flags_t flags;

    clm_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .cw      (cw)
    );

    clm_datapath #(.NODES(NODES)) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cw      (cw),
        .flags   (flags),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// testbench for the list manager core: directed and random requests checked against a list model
`timescale 1ns / 1ps

module testbench;
    import clm_pkg::*;

    localparam logic [1:0] ACT_FRONT    = 2'd0;
    localparam logic [1:0] ACT_BACK     = 2'd1;
    localparam logic [1:0] ACT_DELETE   = 2'd2;
    localparam logic [1:0] ACT_DELETE_3 = 2'd3;  // spare code, decodes as delete
    localparam int RANDOM_ITEMS = 540;
    localparam int DRAIN_CYCLES = 40;

    class list_scoreboard;
        localparam int SLOTS = 16;
        localparam logic [4:0] NIL = 5'd16;

        logic [4:0]  list_head;
        logic [4:0]  free_head;
        logic [4:0]  next_link [SLOTS];
        logic [31:0] node_value [SLOTS];
        clm_out_t    pending_q [$];
        int          errors;

        function new();
            int i;
            for (i = 0; i < SLOTS; i++) begin
                next_link[i]  = 5'(i + 1);
                node_value[i] = '0;
            end
            list_head = NIL;
            free_head = '0;
            errors    = 0;
        endfunction

        function logic [4:0] link_of(input logic [4:0] s);
            if (s >= SLOTS) return NIL;
            return (next_link[s[3:0]] < SLOTS) ? next_link[s[3:0]] : NIL;
        endfunction

        // updates the list image and returns the result the block must give
        function clm_out_t apply_request(input clm_in_t req);
            clm_out_t   res;
            logic [4:0] s;
            logic [4:0] cur;
            logic [4:0] prev;
            logic [4:0] nx;
            int         steps;
            res.status = ST_DONE;
            res.slot   = '0;
            if (!req.action[ACT_DEL_BIT]) begin
                s = free_head;
                if (s >= SLOTS) begin
                    res.status = ST_FULL;
                    return res;
                end
                free_head            = link_of(s);
                node_value[s[3:0]]   = req.value;
                if (!req.action[ACT_BACK_BIT]) begin
                    next_link[s[3:0]] = (list_head < SLOTS) ? list_head : NIL;
                    list_head         = s;
                end else begin
                    next_link[s[3:0]] = NIL;
                    if (list_head >= SLOTS) begin
                        list_head = s;
                    end else begin
                        cur = list_head;
                        for (steps = 0; steps < SLOTS; steps++) begin
                            nx = link_of(cur);
                            if (nx >= SLOTS) break;
                            cur = nx;
                        end
                        next_link[cur[3:0]] = s;
                    end
                end
                res.slot = s[3:0];
                return res;
            end
            prev = NIL;
            cur  = (list_head < SLOTS) ? list_head : NIL;
            for (steps = 0; steps < SLOTS && cur < SLOTS; steps++) begin
                if (node_value[cur[3:0]] == req.value) break;
                prev = cur;
                cur  = link_of(cur);
            end
            if (cur >= SLOTS || node_value[cur[3:0]] != req.value) begin
                res.status = ST_MISSING;
                return res;
            end
            if (prev < SLOTS) begin
                next_link[prev[3:0]] = link_of(cur);
            end else begin
                list_head = link_of(cur);
            end
            // freed slot goes to the front of the free list
            next_link[cur[3:0]] = (free_head < SLOTS) ? free_head : NIL;
            free_head           = cur;
            res.slot            = cur[3:0];
            return res;
        endfunction

        function void record_request(input clm_in_t req);
            pending_q.push_back(apply_request(req));
        endfunction

        function void check_reply(input clm_out_t got);
            clm_out_t want;
            if (pending_q.size() == 0) begin
                $display("%0t: result with nothing expected: status %0d slot %0d",
                         $time, got.status, got.slot);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status mismatch: expected %0d actual %0d",
                         $time, want.status, got.status);
                errors++;
            end
            if (got.slot !== want.slot) begin
                $display("%0t: slot mismatch: expected %0d actual %0d",
                         $time, want.slot, got.slot);
                errors++;
            end
        endfunction

        // a value currently held on the list, so deletes can hit
        function bit pick_listed(output logic [31:0] v);
            logic [31:0] vals [$];
            logic [4:0]  cur;
            int          n;
            cur = list_head;
            n   = 0;
            while (cur < SLOTS && n < SLOTS) begin
                vals.push_back(node_value[cur[3:0]]);
                cur = next_link[cur[3:0]];
                n++;
            end
            if (vals.size() == 0) return 1'b0;
            v = vals[$urandom_range(0, vals.size() - 1)];
            return 1'b1;
        endfunction
    endclass

    logic     aclk = 1'b0;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    clm_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    clm_out_t m_data;
    int       send_idle = 33;
    int       recv_idle = 66;

    list_scoreboard sb = new();

    cursor_linked_list_manager_core #(
        .NODES(16)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // result is checked before the new item is noted: both can move on one edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_reply(m_data);
            if (s_valid && s_ready) sb.record_request(s_data);
        end
    end

    task automatic send_item(input clm_in_t req);
        while ($urandom_range(0, 99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do begin
            @(posedge aclk);
        end while (!s_ready);
    endtask

    task automatic request(input logic [1:0] action, input logic [31:0] value);
        clm_in_t req;
        req.action = action;
        req.value  = value;
        send_item(req);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_q.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_value(input bit want_hit);
        logic [31:0] v;
        if (want_hit && sb.pick_listed(v)) return v;
        case ($urandom_range(0, 3))
            0: v = $urandom_range(0, 7);  // small pool breeds duplicates
            1: v = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic clm_in_t random_request(input int insert_pct);
        clm_in_t req;
        if ($urandom_range(0, 99) < insert_pct) begin
            req.action = $urandom_range(0, 1) ? ACT_BACK : ACT_FRONT;
            req.value  = pick_value(1'b0);
        end else begin
            req.action = ($urandom_range(0, 3) == 0) ? ACT_DELETE_3 : ACT_DELETE;
            req.value  = pick_value($urandom_range(0, 99) < 70);
        end
        return req;
    endfunction

    initial begin
        int phase;
        int i;
        s_valid <= 1'b0;
        s_data  <= '0;
        m_ready <= 1'b0;
        aresetn <= 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        request(ACT_DELETE, 32'h0000_0000);    // delete on an empty list
        request(ACT_BACK, 32'h7fff_ffff);      // back insert onto an empty list
        request(ACT_FRONT, 32'h8000_0000);
        request(ACT_FRONT, 32'hffff_ffff);
        request(ACT_BACK, 32'h0000_0000);
        request(ACT_BACK, 32'h0000_0005);
        request(ACT_FRONT, 32'h0000_0005);
        request(ACT_DELETE, 32'h0000_0005);    // duplicate: the one nearest the head goes
        request(ACT_DELETE_3, 32'h0000_0005);
        request(ACT_DELETE, 32'h1234_5678);    // absent value
        request(ACT_DELETE, 32'h8000_0000);    // middle node
        for (i = 1; i <= 13; i++) request(ACT_BACK, 32'(i * 32'h0101_0101));
        request(ACT_FRONT, 32'hdead_beef);     // store full
        request(ACT_BACK, 32'h0000_0001);
        request(ACT_DELETE, 32'h0d0d_0d0d);    // tail of a full list

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle = 33;
                    recv_idle = 66;
                end
                1: begin
                    send_idle = 66;
                    recv_idle = 33;
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            wait_drained();
            // alternate growing and shrinking runs so the list swings full and empty
            for (i = 0; i < RANDOM_ITEMS / 3; i++)
                send_item(random_request(((i / 30) % 2 == 0) ? 75 : 30));
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("cursor_linked_list_manager_core test passed");
        end else begin
            $display("cursor_linked_list_manager_core test failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("cursor_linked_list_manager_core test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/clm_pkg.sv
rtl/clm_ram.sv
rtl/clm_seq.sv
rtl/clm_datapath.sv
rtl/cursor_linked_list_manager_core.sv
dv/testbench.sv
